// ===== rtl/core/dkpq_pkg.sv =====
// dkpq_pkg: shared types and codes for the dual key priority queue
// no dependencies
`timescale 1ns / 1ps
package dkpq_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT   = 3'd0,
    REQ_POP_WINS = 3'd1,
    REQ_POP_LOSS = 3'd2,
    REQ_PURGE    = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] wins;
    logic [15:0] losses;
  } rec_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_GET,
    ST_PURGE_RD,
    ST_PURGE_CMP,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_REM_RD,
    ST_REM_LAST,
    ST_DN_RD_L,
    ST_DN_RD_R,
    ST_DN_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_NEXT,
    ST_TOP_RD,
    ST_TOP_WAIT
  } state_t;

endpackage

// ===== rtl/core/dual_key_priority_queue.sv =====
// dual_key_priority_queue: two heaps (max wins, min losses) in synchronous rams
// with a sequencer for insert, pop, purge and clear; uses dkpq_pkg
`timescale 1ns / 1ps
//
//  channel  dir  ports                                          handshake
//  in       in   in_req_type in_team_id in_wins_value ...       in_valid/in_stall
//  out      out  out_top_wins_id ... out_dropped                out_valid/out_stall
//
//  one beat in work at a time; each ram read is registered before its compare
//  clear, drop and no-op beats go straight to the top read; insert sifts up one heap, then the other
//  pops sift down level by level and search the other heap for the twin entry by entry, up to
//  capacity entries; purge repeats its entry by entry scan for every removed record
//  reset clears the count and control only; ram entries at or past the count are read only where the data goes unused
//  in_stall is high while a beat is in work; a waiting result holds only the sequencer
module dual_key_priority_queue
  import dkpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_team_id,
  input  logic [15:0] in_wins_value,
  input  logic [15:0] in_losses_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_top_wins_id,
  output logic [15:0] out_top_wins_count,
  output logic [15:0] out_least_losses_id,
  output logic [15:0] out_least_losses_count,
  output logic [6:0]  out_entry_count,
  output logic        out_is_empty,
  output logic        out_dropped
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  rec_t wmem [CAPACITY];
  rec_t lmem [CAPACITY];

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0]  req_r, req_nxt;
  rec_t        rec_r, rec_nxt;
  logic [15:0] pw_r, pw_nxt;
  logic        drop_r, drop_nxt;
  logic        heap_r, heap_nxt;       // 0 wins heap, 1 losses heap
  logic        second_r, second_nxt;   // twin removal phase
  logic [CW-1:0] n_r, n_nxt;           // heap size for current removal
  logic [AW-1:0] i_r, i_nxt;           // hole index
  rec_t        cur_r, cur_nxt;         // record that fills the hole
  rec_t        lc_r, lc_nxt;
  logic        ohv_r, ohv_nxt;         // right child present
  logic        mv_r, mv_nxt;           // sift down moved the hole
  logic [CW-1:0] scan_r, scan_nxt;

  // ram ports
  logic [AW-1:0] rd_addr;
  rec_t        wq, lq, rq;
  logic        we;
  logic [AW-1:0] wa;
  rec_t        wd;

  always_ff @(posedge clk) begin
    if (we && !heap_r) wmem[wa] <= wd;
    if (we && heap_r) lmem[wa] <= wd;
    wq <= wmem[rd_addr];
    lq <= lmem[rd_addr];
  end
  assign rq = heap_r ? lq : wq;

  // output register
  logic        ov_r, ov_nxt;
  rec_t        tw_r, tw_nxt, tl_r, tl_nxt;
  logic [6:0]  oc_r, oc_nxt;
  logic        od_r, od_nxt;
  logic        oe_r, oe_nxt;

  function automatic logic better(input logic h, input rec_t a, input rec_t b);
    better = h ? (a.losses < b.losses) : (a.wins > b.wins);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    req_r <= req_nxt; rec_r <= rec_nxt; pw_r <= pw_nxt; drop_r <= drop_nxt;
    heap_r <= heap_nxt; second_r <= second_nxt; n_r <= n_nxt;
    i_r <= i_nxt; cur_r <= cur_nxt; lc_r <= lc_nxt;
    ohv_r <= ohv_nxt; mv_r <= mv_nxt; scan_r <= scan_nxt;
    tw_r <= tw_nxt; tl_r <= tl_nxt; oc_r <= oc_nxt; od_r <= od_nxt; oe_r <= oe_nxt;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_top_wins_id = tw_r.id;
  assign out_top_wins_count = tw_r.wins;
  assign out_least_losses_id = tl_r.id;
  assign out_least_losses_count = tl_r.losses;
  assign out_entry_count = oc_r;
  assign out_is_empty = oe_r;
  assign out_dropped = od_r;

  logic [AW:0]   lidx, ridx, cidx;
  logic [AW-1:0] pidx;
  logic          pick_r;
  rec_t          ch;
  assign lidx = {i_r, 1'b1};
  assign ridx = lidx + (AW+1)'(1);
  assign pidx = (i_r - AW'(1)) >> 1;
  assign pick_r = ohv_r && better(heap_r, rq, lc_r);
  assign ch = pick_r ? rq : lc_r;
  assign cidx = pick_r ? ridx : lidx;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; req_nxt = req_r; rec_nxt = rec_r;
    pw_nxt = pw_r; drop_nxt = drop_r; heap_nxt = heap_r; second_nxt = second_r;
    n_nxt = n_r; i_nxt = i_r; cur_nxt = cur_r; lc_nxt = lc_r;
    ohv_nxt = ohv_r; mv_nxt = mv_r; scan_nxt = scan_r;
    ov_nxt = ov_r && out_stall;
    tw_nxt = tw_r; tl_nxt = tl_r; oc_nxt = oc_r; od_nxt = od_r; oe_nxt = oe_r;
    rd_addr = '0;
    we = 1'b0; wa = i_r; wd = cur_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          req_nxt  = in_req_type;
          rec_nxt  = '{id: in_team_id, wins: in_wins_value, losses: in_losses_value};
          pw_nxt   = in_wins_value;
          drop_nxt = 1'b0;
          second_nxt = 1'b0;
          heap_nxt = 1'b0;
          scan_nxt = '0;
          mv_nxt = 1'b0;
          state_nxt = ST_TOP_RD;
          case (in_req_type)
            REQ_INSERT: begin
              if (cnt_r >= CW'(CAPACITY)) drop_nxt = 1'b1;
              else begin
                i_nxt = AW'(cnt_r);
                cur_nxt = rec_nxt;
                state_nxt = ST_UP_RD;
              end
            end
            REQ_POP_WINS, REQ_POP_LOSS: begin
              if (cnt_r != '0) begin
                heap_nxt = (in_req_type == REQ_POP_LOSS);
                state_nxt = ST_POP_RD;
              end
            end
            REQ_PURGE: state_nxt = ST_PURGE_RD;
            REQ_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end
      end

      // pop: fetch the top record of the popped heap
      ST_POP_RD: begin
        rd_addr = '0;
        state_nxt = ST_POP_GET;
      end
      ST_POP_GET: begin
        rec_nxt = rq;
        i_nxt = '0;
        n_nxt = cnt_r;
        state_nxt = ST_REM_RD;
      end

      // purge scan of wins heap from the lowest index
      ST_PURGE_RD: begin
        if (scan_r >= cnt_r) state_nxt = ST_TOP_RD;
        else begin
          rd_addr = AW'(scan_r);
          state_nxt = ST_PURGE_CMP;
        end
      end
      ST_PURGE_CMP: begin
        if (wq.wins == pw_r) begin
          rec_nxt = wq;
          heap_nxt = 1'b0;
          i_nxt = AW'(scan_r);
          n_nxt = cnt_r;
          second_nxt = 1'b0;
          state_nxt = ST_REM_RD;
        end else begin
          scan_nxt = scan_r + CW'(1);
          state_nxt = ST_PURGE_RD;
        end
      end

      // twin search in the other heap
      ST_FIND_RD: begin
        if (scan_r >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          second_nxt = 1'b0;
          heap_nxt = 1'b0;
          scan_nxt = '0;
          state_nxt = (req_r == REQ_PURGE) ? ST_PURGE_RD : ST_TOP_RD;
        end else begin
          rd_addr = AW'(scan_r);
          state_nxt = ST_FIND_CMP;
        end
      end
      ST_FIND_CMP: begin
        if (rq == rec_r) begin
          i_nxt = AW'(scan_r);
          n_nxt = cnt_r;
          state_nxt = ST_REM_RD;
        end else begin
          scan_nxt = scan_r + CW'(1);
          state_nxt = ST_FIND_RD;
        end
      end

      // removal at i_r of heap heap_r with n_r entries: last entry fills the hole
      ST_REM_RD: begin
        rd_addr = AW'(n_r - CW'(1));
        state_nxt = ST_REM_LAST;
      end
      ST_REM_LAST: begin
        cur_nxt = rq;
        n_nxt = n_r - CW'(1);
        mv_nxt = 1'b0;
        if (CW'(i_r) < n_r - CW'(1)) state_nxt = ST_DN_RD_L;
        else state_nxt = ST_NEXT;
      end

      // sift down holding cur_r outside the ram
      ST_DN_RD_L: begin
        if (lidx >= (AW+1)'(n_r)) begin
          if (mv_r) begin
            we = 1'b1;
            state_nxt = ST_NEXT;
          end else state_nxt = ST_UP_RD;
        end else begin
          rd_addr = AW'(lidx);
          state_nxt = ST_DN_RD_R;
        end
      end
      ST_DN_RD_R: begin
        lc_nxt = rq;
        ohv_nxt = (ridx < (AW+1)'(n_r));
        rd_addr = AW'(ridx);
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (better(heap_r, ch, cur_r)) begin
          we = 1'b1;
          wd = ch;
          i_nxt = AW'(cidx);
          mv_nxt = 1'b1;
          state_nxt = ST_DN_RD_L;
        end else if (mv_r) begin
          we = 1'b1;
          state_nxt = ST_NEXT;
        end else state_nxt = ST_UP_RD;
      end

      // sift up holding cur_r outside the ram
      ST_UP_RD: begin
        if (i_r == '0) begin
          we = 1'b1;
          state_nxt = ST_NEXT;
        end else begin
          rd_addr = pidx;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (better(heap_r, cur_r, rq)) begin
          wd = rq;
          i_nxt = pidx;
          state_nxt = ST_UP_RD;
        end else state_nxt = ST_NEXT;
      end

      // one heap finished
      ST_NEXT: begin
        if (req_r == REQ_INSERT) begin
          if (!heap_r) begin
            heap_nxt = 1'b1;
            i_nxt = AW'(cnt_r);
            cur_nxt = rec_r;
            state_nxt = ST_UP_RD;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
            state_nxt = ST_TOP_RD;
          end
        end else if (!second_r) begin
          second_nxt = 1'b1;
          heap_nxt = !heap_r;
          scan_nxt = '0;
          state_nxt = ST_FIND_RD;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          second_nxt = 1'b0;
          heap_nxt = 1'b0;
          scan_nxt = '0;
          state_nxt = (req_r == REQ_PURGE) ? ST_PURGE_RD : ST_TOP_RD;
        end
      end

      ST_TOP_RD: begin
        rd_addr = '0;
        state_nxt = ST_TOP_WAIT;
      end
      ST_TOP_WAIT: begin
        rd_addr = '0;
        if (!(ov_r && out_stall)) begin
          tw_nxt = (cnt_r == '0) ? '0 : wq;
          tl_nxt = (cnt_r == '0) ? '0 : lq;
          oc_nxt = 7'(cnt_r);
          oe_nxt = (cnt_r == '0);
          od_nxt = drop_r;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for dual_key_priority_queue, with a heap predictor,
// a burst driver, a stalling receiver and a whole-status result check
// depends on dkpq_pkg and dual_key_priority_queue
`timescale 1ns / 1ps
module tb;
  import dkpq_pkg::*;

  localparam int CAP = 64;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] id;
    logic [15:0] wins;
    logic [15:0] losses;
  } job_t;

  typedef struct packed {
    logic [15:0] tw_id;
    logic [15:0] tw_cnt;
    logic [15:0] ll_id;
    logic [15:0] ll_cnt;
    logic [6:0]  cnt;
    logic        empty;
    logic        drop;
  } status_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_req_type = '0;
  logic [15:0] in_team_id = '0, in_wins_value = '0, in_losses_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] out_top_wins_id, out_top_wins_count, out_least_losses_id;
  logic [15:0] out_least_losses_count;
  logic [6:0] out_entry_count;
  logic out_is_empty, out_dropped;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  dual_key_priority_queue #(.CAPACITY(CAP)) dut (.*);

  // predictor state
  rec_t wheap [CAP];
  rec_t lheap [CAP];
  int held = 0;

  job_t pending_jobs[$];
  status_t status_due[$];
  int mismatches = 0;
  int cycles = 0;
  bit stim_done = 0;
  bit hold_sender = 0;
  bit long_stall = 0;

  function automatic bit better(bit on_losses, rec_t a, rec_t b);
    return on_losses ? (a.losses < b.losses) : (a.wins > b.wins);
  endfunction

  function automatic void heap_up(bit on_losses, int i);
    rec_t t;
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (on_losses) begin
        if (!better(1, lheap[i], lheap[p])) break;
        t = lheap[i]; lheap[i] = lheap[p]; lheap[p] = t;
      end else begin
        if (!better(0, wheap[i], wheap[p])) break;
        t = wheap[i]; wheap[i] = wheap[p]; wheap[p] = t;
      end
      i = p;
    end
  endfunction

  function automatic void heap_down(bit on_losses, int i, int n);
    rec_t t;
    int l, c;
    forever begin
      l = 2 * i + 1;
      if (l >= n) break;
      c = l;
      if (on_losses) begin
        if (l + 1 < n && better(1, lheap[l + 1], lheap[l])) c = l + 1;
        if (!better(1, lheap[c], lheap[i])) break;
        t = lheap[i]; lheap[i] = lheap[c]; lheap[c] = t;
      end else begin
        if (l + 1 < n && better(0, wheap[l + 1], wheap[l])) c = l + 1;
        if (!better(0, wheap[c], wheap[i])) break;
        t = wheap[i]; wheap[i] = wheap[c]; wheap[c] = t;
      end
      i = c;
    end
  endfunction

  function automatic void heap_delete(bit on_losses, int i, int n);
    if (i >= n) return;
    if (on_losses) lheap[i] = lheap[n - 1];
    else wheap[i] = wheap[n - 1];
    if (i < n - 1) begin
      heap_down(on_losses, i, n - 1);
      heap_up(on_losses, i);
    end
  endfunction

  // remove one record from the given heap at i and its twin from the other
  function automatic void drop_record(bit from_losses, int i);
    rec_t r;
    int j;
    r = from_losses ? lheap[i] : wheap[i];
    heap_delete(from_losses, i, held);
    for (j = 0; j < held; j++)
      if ((from_losses ? wheap[j] : lheap[j]) == r) break;
    if (j < held) heap_delete(!from_losses, j, held);
    held--;
  endfunction

  function automatic status_t apply_job(job_t j);
    status_t s;
    int i;
    bit drop = 0;
    case (j.req)
      REQ_INSERT: begin
        if (held >= CAP) drop = 1;
        else begin
          wheap[held] = '{j.id, j.wins, j.losses};
          lheap[held] = '{j.id, j.wins, j.losses};
          heap_up(0, held);
          heap_up(1, held);
          held++;
        end
      end
      REQ_POP_WINS: if (held > 0) drop_record(0, 0);
      REQ_POP_LOSS: if (held > 0) drop_record(1, 0);
      REQ_PURGE: begin
        forever begin
          for (i = 0; i < held; i++)
            if (wheap[i].wins == j.wins) break;
          if (i >= held) break;
          drop_record(0, i);
        end
      end
      REQ_CLEAR: held = 0;
      default: ;
    endcase
    s = '0;
    if (held > 0) begin
      s.tw_id = wheap[0].id;
      s.tw_cnt = wheap[0].wins;
      s.ll_id = lheap[0].id;
      s.ll_cnt = lheap[0].losses;
    end
    s.cnt = held[6:0];
    s.empty = (held == 0);
    s.drop = drop;
    return s;
  endfunction

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        status_due.insert(status_due.size(), apply_job('{in_req_type, in_team_id,
                                                          in_wins_value, in_losses_value}));
        void'(pending_jobs.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (gap_left > 0 || hold_sender || pending_jobs.size() == 0) begin
        in_valid <= 0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1;
        in_req_type <= pending_jobs[0].req;
        in_team_id <= pending_jobs[0].id;
        in_wins_value <= pending_jobs[0].wins;
        in_losses_value <= pending_jobs[0].losses;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    status_t got, want;
    cycles <= cycles + 1;
    if (rst_n) begin
      stall_phase <= stall_phase + 1;
      if (long_stall) out_stall <= 1;
      else if (stall_phase[9]) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 3) == 0);
      if (out_valid && !out_stall) begin
        got = '{out_top_wins_id, out_top_wins_count, out_least_losses_id,
                out_least_losses_count, out_entry_count, out_is_empty, out_dropped};
        if (status_due.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected beat: %p", got);
        end else begin
          want = status_due.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic job_t rand_job(int pool);
    job_t j;
    int k;
    k = $urandom_range(0, 99);
    j.id = 16'($urandom());
    j.losses = 16'($urandom());
    j.wins = (pool > 0) ? 16'($urandom_range(0, pool)) : 16'($urandom());
    if (k < 50) j.req = REQ_INSERT;
    else if (k < 68) j.req = REQ_POP_WINS;
    else if (k < 86) j.req = REQ_POP_LOSS;
    else if (k < 95) j.req = REQ_PURGE;
    else if (k < 97) j.req = REQ_CLEAR;
    else j.req = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 3) == 0) j.losses = 16'($urandom_range(0, 7));
    return j;
  endfunction

  initial begin
    int n, k;
    job_t j;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed part
    pending_jobs.insert(pending_jobs.size(), '{REQ_POP_WINS, 16'd1, 16'd1, 16'd1});
    pending_jobs.insert(pending_jobs.size(), '{REQ_POP_LOSS, 16'd1, 16'd1, 16'd1});
    pending_jobs.insert(pending_jobs.size(), '{REQ_PURGE, 16'd0, 16'd0, 16'd0});
    pending_jobs.insert(pending_jobs.size(), '{REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000});
    pending_jobs.insert(pending_jobs.size(), '{REQ_INSERT, 16'h0000, 16'h0000, 16'hFFFF});
    pending_jobs.insert(pending_jobs.size(), '{REQ_INSERT, 16'h5555, 16'h8000, 16'h8000});
    pending_jobs.insert(pending_jobs.size(), '{REQ_INSERT, 16'h5555, 16'h8000, 16'h8000});
    pending_jobs.insert(pending_jobs.size(), '{REQ_INSERT, 16'hAAAA, 16'h8000, 16'h0000});
    pending_jobs.insert(pending_jobs.size(), '{3'd5, 16'h1234, 16'h8000, 16'h0});
    pending_jobs.insert(pending_jobs.size(), '{3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_jobs.insert(pending_jobs.size(), '{REQ_POP_WINS, 16'd0, 16'd0, 16'd0});
    pending_jobs.insert(pending_jobs.size(), '{REQ_POP_LOSS, 16'd0, 16'd0, 16'd0});
    pending_jobs.insert(pending_jobs.size(), '{REQ_PURGE, 16'd0, 16'h8000, 16'd0});
    pending_jobs.insert(pending_jobs.size(), '{REQ_CLEAR, 16'd0, 16'd0, 16'd0});
    // fill past capacity to hit the drop case
    for (k = 0; k < CAP + 2; k++)
      pending_jobs.insert(pending_jobs.size(),
                          '{REQ_INSERT, 16'(k), 16'($urandom_range(0, 3)), 16'($urandom())});
    pending_jobs.insert(pending_jobs.size(), '{REQ_PURGE, 16'd0, 16'd2, 16'd0});
    pending_jobs.insert(pending_jobs.size(), '{REQ_CLEAR, 16'd0, 16'd0, 16'd0});
    wait (pending_jobs.size() == 0);
    // sender pauses until every result is back
    hold_sender = 1;
    wait (status_due.size() == 0 && !in_valid);
    hold_sender = 0;
    for (n = 0; n < 1050; n++) begin
      j = rand_job((n % 300 < 150) ? 6 : 0);
      pending_jobs.insert(pending_jobs.size(), j);
      if (n == 400) begin
        wait (pending_jobs.size() < 20);
        // long receiver hold while the sender keeps offering
        long_stall = 1;
        repeat (300) @(posedge clk);
        long_stall = 0;
      end
    end
    wait (pending_jobs.size() == 0);
    wait (status_due.size() == 0 && !in_valid);
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/dkpq_pkg.sv
rtl/core/dual_key_priority_queue.sv
bench/tb.sv
